// ----- hw/rtl/fixed_point_square_root_top_defines.svh -----
// Assertion macros used by the square root pipeline stage.
`ifndef FIXED_POINT_SQUARE_ROOT_TOP_DEFINES_SVH
`define FIXED_POINT_SQUARE_ROOT_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FPSQRT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define FPSQRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/fpsqrt_pkg.sv -----
// Constants, types and helpers for the fixed-point square root pipeline.
`default_nettype none

package fpsqrt_pkg;

   localparam logic [31:0] FPSQRT_MAX_OPERAND    = 32'd65535;
   localparam logic [31:0] FPSQRT_FIRST_WEIGHT   = 32'h4000_0000;
   localparam int unsigned FPSQRT_STEPS          = 16;
   localparam int unsigned FPSQRT_STEPS_PER_STAGE = 2;
   localparam int unsigned FPSQRT_STAGES = FPSQRT_STEPS / FPSQRT_STEPS_PER_STAGE;
   localparam int unsigned FPSQRT_ROOT_W = 16;

   typedef struct packed {
      logic [31:0] rem;
      logic [31:0] root;
   } fpsqrt_data_type;

   // Bit weight tested at a given digit step.
   function automatic logic [31:0] fpsqrt_weight(input int unsigned step);
      return FPSQRT_FIRST_WEIGHT >> (2 * step);
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/fpsqrt_stage.sv -----
// One pipeline stage of the square root: two restoring digit steps and a register.
`default_nettype none

`include "fixed_point_square_root_top_defines.svh"

module fpsqrt_stage
   import fpsqrt_pkg::*;
#(
   parameter int unsigned STAGE_IDX = 0
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            up_valid,
   input  wire fpsqrt_data_type up_data,
   output logic                 up_stall,
   output logic                 dn_valid,
   output fpsqrt_data_type      dn_data,
   input  wire logic            dn_stall
);

   localparam int unsigned FIRST_STEP = STAGE_IDX * FPSQRT_STEPS_PER_STAGE;

   logic            valid_ff;
   logic            valid_in;
   fpsqrt_data_type data_ff;
   fpsqrt_data_type data_in;

   always_comb begin
      logic [31:0] rem_v;
      logic [31:0] root_v;
      logic [31:0] weight_v;
      logic [31:0] trial_v;
      rem_v  = up_data.rem;
      root_v = up_data.root;
      for (int j = 0; j < FPSQRT_STEPS_PER_STAGE; j++) begin
         weight_v = fpsqrt_weight(FIRST_STEP + j);
         trial_v  = weight_v + root_v;
         root_v   = root_v >> 1;
         if (trial_v <= rem_v) begin
            rem_v  = rem_v - trial_v;
            root_v = root_v | weight_v;
         end
      end
      data_in.rem  = rem_v;
      data_in.root = root_v;
   end

   // hold while a full stage faces a stalled neighbor
   assign up_stall = valid_ff && dn_stall;
   assign valid_in = up_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!up_stall) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!up_stall && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

   `FPSQRT_ASSERT_NOW(a_stall_only_when_full, clock, reset, up_stall, valid_ff && dn_stall, "stage stalls upstream while empty")
   `FPSQRT_ASSERT_NEXT(a_stalled_item_kept, clock, reset, valid_ff && dn_stall, valid_ff && $stable(data_ff), "stalled item lost or changed")
   `FPSQRT_ASSERT_NEXT(a_item_taken, clock, reset, up_valid && !up_stall, valid_ff, "accepted item dropped")

endmodule

`default_nettype wire

// ----- hw/rtl/fixed_point_square_root_top.sv -----
// Top level of the pipelined 8.8 fixed-point square root.
//
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_stall  | req_operand[31:0]
//  rsp     | out       | rsp_valid / rsp_stall  | rsp_root[15:0]
//
// Throughput: one item per cycle with no stall on the result side.
// The root passes through eight register stages of two digit steps each.
// Reset clears every stage valid bit; data registers are not reset.
// A stall holds full stages only; empty stages ahead of it keep filling.
// Operands above 65535 enter with a zero remainder and come out as zero.
`default_nettype none

module fixed_point_square_root_top
   import fpsqrt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic [31:0] req_operand,
   output logic             req_stall,
   output logic             rsp_valid,
   output logic [15:0]      rsp_root,
   input  wire logic        rsp_stall
);

   logic            stg_valid [FPSQRT_STAGES+1];
   logic            stg_stall [FPSQRT_STAGES+1];
   fpsqrt_data_type stg_data  [FPSQRT_STAGES+1];

   // zero remainder forces every trial to fail, giving a zero root
   always_comb begin
      stg_data[0].root = '0;
      if (req_operand > FPSQRT_MAX_OPERAND) begin
         stg_data[0].rem = '0;
      end else begin
         stg_data[0].rem = {req_operand[15:0], 16'h0000};
      end
   end

   assign stg_valid[0] = req_valid;
   assign req_stall    = stg_stall[0];

   for (genvar s = 0; s < FPSQRT_STAGES; s++) begin : g_stage
      fpsqrt_stage #(
         .STAGE_IDX (s)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .up_valid (stg_valid[s]),
         .up_data  (stg_data[s]),
         .up_stall (stg_stall[s]),
         .dn_valid (stg_valid[s+1]),
         .dn_data  (stg_data[s+1]),
         .dn_stall (stg_stall[s+1])
      );
   end

   assign stg_stall[FPSQRT_STAGES] = rsp_stall;
   assign rsp_valid = stg_valid[FPSQRT_STAGES];
   assign rsp_root  = stg_data[FPSQRT_STAGES].root[FPSQRT_ROOT_W-1:0];

endmodule

`default_nettype wire
